/* rtl/alrm_pkg.sv */
package alrm_pkg;

  // pattern characters held per pattern register, and the line buffer size
  localparam int PATTERN_CHARS    = 8;
  localparam int LINE_BUFFER_SIZE = 256;

  // line control characters
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  // reset values of the configuration registers
  localparam logic [23:0] TIMEOUT_TICKS_RST = 24'd600000;
  localparam logic [7:0]  LINE_LIMIT_RST    = 8'd255;

  // largest usable line limit
  localparam logic [7:0] LIMIT_CAP   = 8'(LINE_BUFFER_SIZE - 1);
  localparam logic [3:0] PAT_LEN_CAP = 4'(PATTERN_CHARS);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS_PATTERN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_PATTERN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT      = 3'd5;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    STAT_SUCCESS  = 3'd0,
    STAT_FAILURE  = 3'd1,
    STAT_ANY_LINE = 3'd2,
    STAT_TIMEOUT  = 3'd3,
    STAT_OVERFLOW = 3'd4
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] line_length;
  } out_item_t;

  typedef struct packed {
    logic [63:0] success_pattern;
    logic [3:0]  success_length;
    logic [63:0] failure_pattern;
    logic [3:0]  failure_length;
    logic [23:0] timeout_ticks;
    logic [7:0]  line_limit;
  } cfg_t;

  typedef struct packed {
    logic        searching;
    logic [7:0]  line_position;
    logic        previous_was_cr;
    logic        success_matching;
    logic        failure_matching;
    logic [23:0] ticks_left;
  } search_state_t;

  // pattern length as used, capped at the pattern register size
  function automatic logic [3:0] clamp_len(input logic [3:0] n);
    return (n > PAT_LEN_CAP) ? PAT_LEN_CAP : n;
  endfunction

  // line limit as used, capped below the line buffer size
  function automatic logic [7:0] eff_limit(input logic [7:0] lim);
    return (lim > LIMIT_CAP) ? LIMIT_CAP : lim;
  endfunction

endpackage

/* rtl/alrm_cfg.sv */
module alrm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [alrm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [alrm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output alrm_pkg::cfg_t                   cfg
);
  import alrm_pkg::*;

  cfg_t cfg_r;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.success_pattern <= '0;
      cfg_r.success_length  <= '0;
      cfg_r.failure_pattern <= '0;
      cfg_r.failure_length  <= '0;
      cfg_r.timeout_ticks   <= TIMEOUT_TICKS_RST;
      cfg_r.line_limit      <= LINE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SUCCESS_PATTERN: cfg_r.success_pattern <= cfg_wdata;
        CFG_SUCCESS_LENGTH:  cfg_r.success_length  <= cfg_wdata[3:0];
        CFG_FAILURE_PATTERN: cfg_r.failure_pattern <= cfg_wdata;
        CFG_FAILURE_LENGTH:  cfg_r.failure_length  <= cfg_wdata[3:0];
        CFG_TIMEOUT_TICKS:   cfg_r.timeout_ticks   <= cfg_wdata[23:0];
        CFG_LINE_LIMIT:      cfg_r.line_limit      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/alrm_step.sv */
module alrm_step (
  input  alrm_pkg::cfg_t          cfg,
  input  alrm_pkg::search_state_t cur,
  input  alrm_pkg::in_item_t      item,
  output alrm_pkg::search_state_t nxt,
  output logic                    res_valid,
  output alrm_pkg::out_item_t     res
);
  import alrm_pkg::*;

  logic [3:0] slen;
  logic [3:0] flen;
  logic [7:0] limit;
  logic [8:0] pos_inc;
  logic [7:0] s_char;
  logic [7:0] f_char;
  logic       s_ok;
  logic       f_ok;
  logic       s_hit;
  logic       f_hit;
  logic       line_end;

  // pattern characters at the current line position
  assign slen    = clamp_len(cfg.success_length);
  assign flen    = clamp_len(cfg.failure_length);
  assign limit   = eff_limit(cfg.line_limit);
  assign pos_inc = {1'b0, cur.line_position} + 9'd1;
  assign s_char  = cfg.success_pattern[{cur.line_position[2:0], 3'b000} +: 8];
  assign f_char  = cfg.failure_pattern[{cur.line_position[2:0], 3'b000} +: 8];

  // running prefix match, including this byte
  assign s_ok = cur.success_matching &&
                !((cur.line_position < {4'b0, slen}) && (s_char != item.rx_byte));
  assign f_ok = cur.failure_matching &&
                !((cur.line_position < {4'b0, flen}) && (f_char != item.rx_byte));

  // pattern hits at a line end
  assign s_hit    = (slen != 4'd0) && ({5'b0, slen} <= pos_inc) && s_ok;
  assign f_hit    = (flen != 4'd0) && ({5'b0, flen} <= pos_inc) && f_ok;
  assign line_end = (item.rx_byte == CH_LF) && cur.previous_was_cr;

  // next search state and result
  always_comb begin
    nxt             = cur;
    res_valid       = 1'b0;
    res.status      = STAT_SUCCESS;
    res.line_length = cur.line_position;
    case (item.op)
      OP_START: begin
        nxt.searching        = 1'b1;
        nxt.ticks_left       = cfg.timeout_ticks;
        nxt.line_position    = '0;
        nxt.previous_was_cr  = 1'b0;
        nxt.success_matching = 1'b1;
        nxt.failure_matching = 1'b1;
      end
      OP_TICK: begin
        if (cur.searching) begin
          if (cur.ticks_left <= 24'd1) begin
            nxt.ticks_left = '0;
            nxt.searching  = 1'b0;
            res_valid      = 1'b1;
            res.status     = STAT_TIMEOUT;
          end else begin
            nxt.ticks_left = cur.ticks_left - 24'd1;
          end
        end
      end
      OP_BYTE: begin
        if (cur.searching) begin
          nxt.success_matching = s_ok;
          nxt.failure_matching = f_ok;
          if (line_end) begin
            if (s_hit) begin
              nxt.searching = 1'b0;
              res_valid     = 1'b1;
              res.status    = STAT_SUCCESS;
            end else if (f_hit) begin
              nxt.searching = 1'b0;
              res_valid     = 1'b1;
              res.status    = STAT_FAILURE;
            end else if (slen == 4'd0 && flen == 4'd0) begin
              nxt.searching = 1'b0;
              res_valid     = 1'b1;
              res.status    = STAT_ANY_LINE;
            end else begin
              // unmatched line, start over
              nxt.line_position    = '0;
              nxt.previous_was_cr  = 1'b0;
              nxt.success_matching = 1'b1;
              nxt.failure_matching = 1'b1;
            end
          end else begin
            nxt.previous_was_cr = (item.rx_byte == CH_CR);
            if (pos_inc >= {1'b0, limit}) begin
              nxt.searching = 1'b0;
              res_valid     = 1'b1;
              res.status    = STAT_OVERFLOW;
            end else begin
              nxt.line_position = pos_inc[7:0];
            end
          end
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/alrm_core.sv */
module alrm_core (
  input  logic                clk,
  input  logic                rst_n,
  input  alrm_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  alrm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output alrm_pkg::out_item_t out_data
);
  import alrm_pkg::*;

  logic          item_valid_r;
  in_item_t      item_r;
  search_state_t state_r;
  search_state_t state_nxt;
  logic          out_valid_r;
  out_item_t     out_data_r;
  logic          res_valid;
  out_item_t     res;
  logic          advance;

  // held item moves on whenever the result register is free or draining
  assign advance  = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  alrm_step u_step (
    .cfg       (cfg),
    .cur       (state_r),
    .item      (item_r),
    .nxt       (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
  end

  // search state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.searching        <= 1'b0;
      state_r.line_position    <= '0;
      state_r.previous_was_cr  <= 1'b0;
      state_r.success_matching <= 1'b1;
      state_r.failure_matching <= 1'b1;
      state_r.ticks_left       <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/at_response_line_matcher.sv */
// Path: a result beat passes the input register, the compare and counter logic and the
// result register; a held beat waits in the input register behind a stalled result.
// Throughput: one input beat per cycle unless a result stalls, set by a single pass of
// compare and counter logic between the input register and the result register.
// Reset: synchronous, active low; clears the search to idle, the line state, the
// tick count and the held beats, and loads the configuration defaults.
module at_response_line_matcher (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [alrm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [alrm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  alrm_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output alrm_pkg::out_item_t              out_data
);
  import alrm_pkg::*;

  cfg_t cfg;

  alrm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  alrm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // input only backs up behind a stalled result
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a stalled result");

  // success needs a configured success pattern
  a_success_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STAT_SUCCESS) |-> (cfg.success_length != 4'd0))
    else $error("success reported with no success pattern");

  // overflow only at the line limit
  a_overflow_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STAT_OVERFLOW) |->
      (({1'b0, out_data.line_length} + 9'd1) >= {1'b0, eff_limit(cfg.line_limit)}))
    else $error("overflow reported below the line limit");
`endif

endmodule

/* dv/tb_top.sv */
module tb_top;
  import alrm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // op code the block has no use for
  localparam op_t OP_UNUSED = op_t'(2'd3);
  // result path runs through the input and result registers, keep a little margin
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_BEATS  = 700;
  localparam int PHASE_BEATS   = 90;

  // tracks the search state and the line events it must end with
  class line_scoreboard;
    logic [63:0] succ_pat;
    logic [3:0]  succ_len;
    logic [63:0] fail_pat;
    logic [3:0]  fail_len;
    logic [23:0] tick_budget;
    logic [7:0]  len_limit;

    bit          armed;
    logic [7:0]  line_pos;
    bit          last_cr;
    bit          succ_ok;
    bit          fail_ok;
    logic [23:0] ticks_rem;

    out_item_t   expected_ends[$];
    int          mismatches;

    function new();
      mismatches  = 0;
      succ_pat    = '0;
      succ_len    = '0;
      fail_pat    = '0;
      fail_len    = '0;
      tick_budget = TIMEOUT_TICKS_RST;
      len_limit   = LINE_LIMIT_RST;
      armed       = 1'b0;
      ticks_rem   = '0;
      clear_line();
    endfunction

    function void clear_line();
      line_pos = '0;
      last_cr  = 1'b0;
      succ_ok  = 1'b1;
      fail_ok  = 1'b1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SUCCESS_PATTERN: succ_pat = val;
        CFG_SUCCESS_LENGTH:  succ_len = val[3:0];
        CFG_FAILURE_PATTERN: fail_pat = val;
        CFG_FAILURE_LENGTH:  fail_len = val[3:0];
        CFG_TIMEOUT_TICKS:   tick_budget = val[23:0];
        CFG_LINE_LIMIT:      len_limit = val[7:0];
        default: ;
      endcase
    endfunction

    // a pattern keeps matching while each byte below its length agrees
    function bit char_agrees(bit flag, logic [63:0] pat, int len, int pos, logic [7:0] ch);
      if (pos < len) begin
        if (pat[8*pos +: 8] != ch) return 1'b0;
      end
      return flag;
    endfunction

    function bit pattern_hit(bit flag, int len, int pos);
      return (len != 0) && (len <= pos + 1) && flag;
    endfunction

    function void end_search(status_t st, logic [7:0] n);
      out_item_t r;
      r.status      = st;
      r.line_length = n;
      expected_ends.push_back(r);
      armed = 1'b0;
    endfunction

    // returns 1 when the search was live or the beat is a start
    function bit track_rx_beat(in_item_t b);
      int pos;
      int slen;
      int flen;
      bit live;
      live = armed || (b.op == OP_START);
      case (b.op)
        OP_START: begin
          armed     = 1'b1;
          ticks_rem = tick_budget;
          clear_line();
        end
        OP_TICK: begin
          if (armed) begin
            if (ticks_rem <= 1) begin
              ticks_rem = '0;
              end_search(STAT_TIMEOUT, line_pos);
            end else begin
              ticks_rem = ticks_rem - 1;
            end
          end
        end
        OP_BYTE: begin
          if (armed) begin
            pos  = line_pos;
            slen = (succ_len > PATTERN_CHARS) ? PATTERN_CHARS : succ_len;
            flen = (fail_len > PATTERN_CHARS) ? PATTERN_CHARS : fail_len;
            succ_ok = char_agrees(succ_ok, succ_pat, slen, pos, b.rx_byte);
            fail_ok = char_agrees(fail_ok, fail_pat, flen, pos, b.rx_byte);
            if (b.rx_byte == CH_LF && last_cr) begin
              // line end: success first, then failure, then any line
              if (pattern_hit(succ_ok, slen, pos)) end_search(STAT_SUCCESS, 8'(pos));
              else if (pattern_hit(fail_ok, flen, pos)) end_search(STAT_FAILURE, 8'(pos));
              else if (slen == 0 && flen == 0) end_search(STAT_ANY_LINE, 8'(pos));
              else clear_line();
            end else begin
              last_cr = (b.rx_byte == CH_CR);
              if (pos + 1 >= int'(len_limit)) end_search(STAT_OVERFLOW, 8'(pos));
              else line_pos = 8'(pos + 1);
            end
          end
        end
        default: ;
      endcase
      return live;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_ends.size() == 0) begin
        $error("result beat with none expected: status %0d line_length %0d",
               got.status, got.line_length);
        mismatches++;
        return;
      end
      want = expected_ends.pop_front();
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.line_length !== want.line_length) begin
        $error("line_length expected %0d actual %0d", want.line_length, got.line_length);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  line_scoreboard sb;
  bit idle_on = 1'b1;
  bit tick_noise = 1'b1;
  int sent_beats = 0;

  at_response_line_matcher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  // result side: check each taken beat, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= !idle_on || ($urandom_range(99) >= 25);
  end

  // one input beat, with an optional gap in front
  task automatic send_beat(input op_t op, input logic [7:0] ch);
    in_item_t b;
    int gap;
    b.op      = op;
    b.rx_byte = ch;
    gap = 0;
    if (idle_on && $urandom_range(99) < 25) gap = $urandom_range(1, 2);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    void'(sb.track_rx_beat(b));
    sent_beats++;
  endtask

  // received byte, sometimes preceded by a tick
  task automatic send_rx(input logic [7:0] ch);
    if (tick_noise && $urandom_range(99) < 8) send_beat(OP_TICK, 8'($urandom));
    send_beat(OP_BYTE, ch);
  endtask

  task automatic send_crlf();
    send_rx(CH_CR);
    send_rx(CH_LF);
  endtask

  // hold off input until every expected line event has come out
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    for (int i = 0; i < 20000 && sb.expected_ends.size() > 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_cfg(input logic [63:0] sp, input logic [3:0] sl,
                           input logic [63:0] fp, input logic [3:0] fl,
                           input logic [23:0] tt, input logic [7:0] ll);
    wait_results_drained();
    write_reg(CFG_SUCCESS_PATTERN, sp);
    write_reg(CFG_SUCCESS_LENGTH, 64'(sl));
    write_reg(CFG_FAILURE_PATTERN, fp);
    write_reg(CFG_FAILURE_LENGTH, 64'(fl));
    write_reg(CFG_TIMEOUT_TICKS, 64'(tt));
    write_reg(CFG_LINE_LIMIT, 64'(ll));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] junk_byte();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return CH_CR;
    if (r == 1) return CH_LF;
    return 8'($urandom_range(0, 255));
  endfunction

  // pattern prefix (sometimes corrupted), a junk tail, then cr lf
  task automatic emit_line(input logic [63:0] pat, input int n, input int tail_max);
    logic [7:0] ch;
    int cnt;
    cnt = (n > PATTERN_CHARS) ? PATTERN_CHARS : n;
    for (int i = 0; i < cnt; i++) begin
      ch = pat[8*i +: 8];
      if ($urandom_range(11) == 0) ch = 8'($urandom);
      send_rx(ch);
    end
    repeat ($urandom_range(0, tail_max)) send_rx(junk_byte());
    send_crlf();
  endtask

  // runs up to or past the line limit without a cr
  task automatic emit_long_line();
    logic [7:0] ch;
    repeat (int'(sb.len_limit) + $urandom_range(0, 2)) begin
      ch = 8'($urandom);
      if (ch == CH_CR) ch = CH_CR + 8'd1;
      send_rx(ch);
    end
  endtask

  // one search: a start and a few lines, mostly well formed
  task automatic run_search();
    int unsigned kind;
    send_beat(OP_START, 8'($urandom));
    repeat ($urandom_range(1, 3)) begin
      kind = $urandom_range(99);
      if (kind < 30) emit_line(sb.succ_pat, sb.succ_len, 3);
      else if (kind < 55) emit_line(sb.fail_pat, sb.fail_len, 3);
      else if (kind < 72) emit_line('0, 0, 8);
      else if (kind < 80) begin
        // broken line ends: lone cr or lone lf
        repeat ($urandom_range(0, 4)) send_rx(junk_byte());
        send_rx(($urandom_range(1) != 0) ? CH_CR : CH_LF);
        send_rx(junk_byte());
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 6)) send_beat(OP_TICK, 8'($urandom));
      end else if (kind < 94) begin
        emit_long_line();
      end else if (kind < 97) begin
        send_beat(OP_UNUSED, 8'($urandom));
      end else begin
        // restart in the middle of a line
        send_rx(junk_byte());
        send_beat(OP_START, 8'($urandom));
      end
    end
  endtask

  // random settings per phase, with a few fixed corners
  task automatic random_cfg(input int phase);
    logic [63:0] sp;
    logic [63:0] fp;
    logic [3:0]  sl;
    logic [3:0]  fl;
    logic [23:0] tt;
    logic [7:0]  ll;
    int unsigned r;
    sp = {$urandom, $urandom};
    fp = {$urandom, $urandom};
    sl = ($urandom_range(99) < 20) ? 4'd0 : 4'($urandom_range(1, 15));
    fl = ($urandom_range(99) < 20) ? 4'd0 : 4'($urandom_range(1, 15));
    r = $urandom_range(99);
    if (r < 10) tt = 24'($urandom_range(0, 1));
    else if (r < 80) tt = 24'($urandom_range(2, 60));
    else tt = 24'($urandom_range(61, 500));
    r = $urandom_range(99);
    if (r < 15) ll = 8'($urandom_range(2, 6));
    else if (r < 70) ll = 8'($urandom_range(7, 40));
    else ll = 8'($urandom_range(41, 255));
    case (phase)
      0: begin
        sl = 4'd0;
        fl = 4'd0;
      end
      1: begin
        sp = '1;
        fp = '0;
        sl = 4'd8;
        fl = 4'd8;
        tt = '1;
        ll = 8'd255;
      end
      3: ll = 8'd0;
      4: begin
        // same prefix on both patterns so priority shows
        fp = sp;
        fl = sl;
      end
      default: ;
    endcase
    apply_cfg(sp, sl, fp, fl, tt, ll);
  endtask

  initial begin
    int phase;
    int phase_start;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle drops, unused op, lf at line start, byte extremes, restart
    send_beat(OP_BYTE, "Z");
    send_beat(OP_TICK, 8'h00);
    send_beat(OP_START, 8'hFF);
    send_beat(OP_UNUSED, 8'h55);
    send_beat(OP_BYTE, CH_LF);
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, CH_CR);
    send_beat(OP_BYTE, CH_LF);
    send_beat(OP_START, 8'h00);
    send_beat(OP_BYTE, "Q");
    send_beat(OP_START, 8'h00);
    send_beat(OP_BYTE, CH_CR);
    send_beat(OP_BYTE, CH_LF);

    // both patterns "OK": success wins; short tick budget runs out
    apply_cfg(64'h4B4F, 4'd2, 64'h4B4F, 4'd2, 24'd2, 8'd255);
    send_beat(OP_START, 8'h00);
    send_beat(OP_BYTE, "O");
    send_beat(OP_BYTE, "K");
    send_beat(OP_BYTE, CH_CR);
    send_beat(OP_BYTE, CH_LF);
    send_beat(OP_START, 8'h00);
    send_beat(OP_TICK, 8'h00);
    send_beat(OP_TICK, 8'hFF);

    // limit of one overflows at once, zero budget times out on first tick
    apply_cfg(64'h0, 4'd12, '1, 4'd15, 24'd0, 8'd1);
    send_beat(OP_START, 8'h00);
    send_beat(OP_BYTE, "A");
    send_beat(OP_START, 8'h00);
    send_beat(OP_TICK, 8'h00);

    // random phases
    sent_beats = 0;
    phase = 0;
    while (sent_beats < RANDOM_BEATS) begin
      random_cfg(phase);
      idle_on = (phase != 2);
      tick_noise = (phase != 1);
      phase_start = sent_beats;
      while (sent_beats - phase_start < PHASE_BEATS && sent_beats < RANDOM_BEATS) run_search();
      phase++;
    end
    idle_on = 1'b1;

    wait_results_drained();
    if (sb.expected_ends.size() != 0) begin
      $error("%0d expected line events never came out", sb.expected_ends.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/alrm_pkg.sv
rtl/alrm_cfg.sv
rtl/alrm_step.sv
rtl/alrm_core.sv
rtl/at_response_line_matcher.sv
dv/tb_top.sv
